### design/ura_pkg.sv
// Shared types, widths and constants of the ultrasonic range averager.
package ura_pkg;

   // field and register widths
   localparam int unsigned TRIG_W  = 8;
   localparam int unsigned TMO_W   = 15;
   localparam int unsigned AVG_W   = 6;
   localparam int unsigned SCALE_W = 16;
   localparam int unsigned DIST_W  = 14;
   localparam int unsigned TICK_W  = 16;
   localparam int unsigned WIDTH_W = 15;
   localparam int unsigned SUM_W   = 20;
   localparam int unsigned PROD_W  = SUM_W + SCALE_W;

   // default depth of the reading counter
   localparam int unsigned MAX_READINGS_DEF = 63;

   // stream and register port sizes
   localparam int unsigned REQ_TDATA_W = 8;
   localparam int unsigned RSP_FIELD_W = 3 + DIST_W + 1;
   localparam int unsigned RSP_TDATA_W = 24;
   localparam int unsigned CSR_ADDR_W  = 5;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [TICK_W-1:0]  LOW_TICKS = TICK_W'(3);
   localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;
   localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
   localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
   localparam logic [TICK_W-1:0]  TICK_MAX  = '1;

   // register reset values
   localparam logic [TRIG_W-1:0]  TRIG_WIDTH_RST = TRIG_W'(10);
   localparam logic [TMO_W-1:0]   TIMEOUT_RST    = TMO_W'(11765);
   localparam logic [AVG_W-1:0]   AVG_COUNT_RST  = AVG_W'(10);
   localparam logic               AVG_ENABLE_RST = 1'b1;
   localparam logic [SCALE_W-1:0] SCALE_RST      = SCALE_W'(2248);
   localparam logic [DIST_W-1:0]  RANGE_RST      = DIST_W'(50);

   typedef enum logic [2:0] {
      REG_TRIGGER_WIDTH = 3'd0,
      REG_TIMEOUT       = 3'd1,
      REG_AVERAGE_COUNT = 3'd2,
      REG_AVERAGING_EN  = 3'd3,
      REG_SPEED_SCALE   = 3'd4,
      REG_OBST_RANGE    = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_LOW  = 3'd1,
      PH_TRIG = 3'd2,
      PH_ECHO = 3'd3,
      PH_GAP  = 3'd4
   } phase_type;

   typedef enum logic {
      CTL_RUN,
      CTL_CALC
   } ctl_state_type;

   typedef enum logic [1:0] {
      CALC_IDLE,
      CALC_DIV,
      CALC_MUL,
      CALC_FIN
   } calc_state_type;

   typedef struct packed {
      logic [TRIG_W-1:0]  trigger_width_us;
      logic [TMO_W-1:0]   timeout_us;
      logic [AVG_W-1:0]   average_count;
      logic               averaging_enable;
      logic [SCALE_W-1:0] speed_scale;
      logic [DIST_W-1:0]  obstacle_range;
   } cfg_type;

   typedef struct packed {
      logic trigger_out;
      logic busy_res;
      logic calc_req;
   } tick_res_type;

   typedef struct packed {
      logic              done;
      logic [DIST_W-1:0] distance_cm;
      logic              obstacle;
   } calc_res_type;

endpackage

### design/ura_csr.sv
// Configuration register file behind the APB-style port.
module ura_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ura_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ura_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ura_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output ura_pkg::cfg_type                    cfg
);

   ura_pkg::cfg_type      cfg_ff, cfg_in;
   ura_pkg::reg_index_type idx;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign idx        = ura_pkg::reg_index_type'(csr_paddr[ura_pkg::CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            ura_pkg::REG_TRIGGER_WIDTH: cfg_in.trigger_width_us = csr_pwdata[ura_pkg::TRIG_W-1:0];
            ura_pkg::REG_TIMEOUT:       cfg_in.timeout_us       = csr_pwdata[ura_pkg::TMO_W-1:0];
            ura_pkg::REG_AVERAGE_COUNT: cfg_in.average_count    = csr_pwdata[ura_pkg::AVG_W-1:0];
            ura_pkg::REG_AVERAGING_EN:  cfg_in.averaging_enable = csr_pwdata[0];
            ura_pkg::REG_SPEED_SCALE:   cfg_in.speed_scale      = csr_pwdata[ura_pkg::SCALE_W-1:0];
            ura_pkg::REG_OBST_RANGE:    cfg_in.obstacle_range   = csr_pwdata[ura_pkg::DIST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         ura_pkg::REG_TRIGGER_WIDTH:
            csr_prdata = ura_pkg::CSR_DATA_W'(cfg_ff.trigger_width_us);
         ura_pkg::REG_TIMEOUT:
            csr_prdata = ura_pkg::CSR_DATA_W'(cfg_ff.timeout_us);
         ura_pkg::REG_AVERAGE_COUNT:
            csr_prdata = ura_pkg::CSR_DATA_W'(cfg_ff.average_count);
         ura_pkg::REG_AVERAGING_EN:
            csr_prdata = ura_pkg::CSR_DATA_W'(cfg_ff.averaging_enable);
         ura_pkg::REG_SPEED_SCALE:
            csr_prdata = ura_pkg::CSR_DATA_W'(cfg_ff.speed_scale);
         ura_pkg::REG_OBST_RANGE:
            csr_prdata = ura_pkg::CSR_DATA_W'(cfg_ff.obstacle_range);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_width_us <= ura_pkg::TRIG_WIDTH_RST;
         cfg_ff.timeout_us       <= ura_pkg::TIMEOUT_RST;
         cfg_ff.average_count    <= ura_pkg::AVG_COUNT_RST;
         cfg_ff.averaging_enable <= ura_pkg::AVG_ENABLE_RST;
         cfg_ff.speed_scale      <= ura_pkg::SCALE_RST;
         cfg_ff.obstacle_range   <= ura_pkg::RANGE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/ura_seq.sv
// Per-tick ranging sequencer: trigger, echo timing, gap and running sum.
module ura_seq #(
   parameter int unsigned MAX_READINGS = ura_pkg::MAX_READINGS_DEF,
   localparam int unsigned CNT_W = $clog2(MAX_READINGS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          start_req,
   input  logic                          echo_level,
   input  ura_pkg::cfg_type              cfg,
   output ura_pkg::tick_res_type         tick_res,
   output logic [ura_pkg::SUM_W-1:0]     sum_out,
   output logic [CNT_W-1:0]              count_out
);

   localparam int unsigned TICK_W  = ura_pkg::TICK_W;
   localparam int unsigned WIDTH_W = ura_pkg::WIDTH_W;
   localparam int unsigned SUM_W   = ura_pkg::SUM_W;
   localparam int unsigned AVG_W   = ura_pkg::AVG_W;

   ura_pkg::phase_type  phase_ff, phase_in;
   logic [TICK_W-1:0]   ticks_ff, ticks_in;
   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic                started_ff, started_in;
   logic [CNT_W-1:0]    taken_ff, taken_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;

   logic [TICK_W-1:0]   ticks_inc, gap_ticks, trig_lim, tmo_lim, gap_lim;
   logic [AVG_W-1:0]    n_raw;
   logic [CNT_W-1:0]    wanted;
   logic                echo_ended, echo_timeout, gap_done, enough;
   logic [WIDTH_W-1:0]  finish_w;
   logic [SUM_W:0]      sum_add;
   logic [SUM_W-1:0]    sum_sat;
   logic [CNT_W-1:0]    taken_inc;

   assign ticks_inc = ticks_ff + TICK_W'(1);
   assign trig_lim  = TICK_W'(cfg.trigger_width_us);
   assign tmo_lim   = TICK_W'(cfg.timeout_us);
   assign gap_lim   = {cfg.timeout_us, 1'b0};
   assign gap_ticks = (ticks_ff == ura_pkg::TICK_MAX) ? ticks_ff : ticks_inc;
   assign gap_done  = gap_ticks >= gap_lim;

   // readings per result, clamped to 1 .. MAX_READINGS
   always_comb begin
      n_raw = cfg.averaging_enable ? cfg.average_count : AVG_W'(1);
      if (n_raw == '0) begin
         wanted = CNT_W'(1);
      end else if (int'(n_raw) > int'(MAX_READINGS)) begin
         wanted = CNT_W'(MAX_READINGS);
      end else begin
         wanted = CNT_W'(n_raw);
      end
   end

   assign enough = taken_ff >= wanted;

   // a pulse end is checked ahead of the timeout
   assign echo_ended   = started_ff & ~echo_level;
   assign echo_timeout = ticks_inc >= tmo_lim;
   assign finish_w     = echo_ended ? width_ff : '0;
   assign sum_add      = {1'b0, sum_ff} + (SUM_W + 1)'(finish_w[WIDTH_W-1:1]);
   assign sum_sat      = sum_add[SUM_W] ? ura_pkg::SUM_MAX : sum_add[SUM_W-1:0];
   assign taken_inc    = (taken_ff == CNT_W'(MAX_READINGS)) ? taken_ff : taken_ff + CNT_W'(1);

   // next state
   always_comb begin
      phase_in   = phase_ff;
      ticks_in   = ticks_ff;
      width_in   = width_ff;
      started_in = started_ff;
      taken_in   = taken_ff;
      sum_in     = sum_ff;
      if (step) begin
         unique case (phase_ff)
            ura_pkg::PH_LOW: begin
               ticks_in = ticks_inc;
               if (ticks_inc >= ura_pkg::LOW_TICKS) begin
                  phase_in = ura_pkg::PH_TRIG;
                  ticks_in = '0;
               end
            end
            ura_pkg::PH_TRIG: begin
               ticks_in = ticks_inc;
               if (ticks_inc >= trig_lim) begin
                  phase_in   = ura_pkg::PH_ECHO;
                  ticks_in   = '0;
                  width_in   = '0;
                  started_in = 1'b0;
               end
            end
            ura_pkg::PH_ECHO: begin
               ticks_in = ticks_inc;
               if (!started_ff) begin
                  if (echo_level) begin
                     started_in = 1'b1;
                     width_in   = WIDTH_W'(1);
                  end
               end else if (echo_level && width_ff != ura_pkg::WIDTH_MAX) begin
                  width_in = width_ff + WIDTH_W'(1);
               end
               if (echo_ended || echo_timeout) begin
                  sum_in   = sum_sat;
                  taken_in = taken_inc;
                  phase_in = ura_pkg::PH_GAP;
                  ticks_in = '0;
               end
            end
            ura_pkg::PH_GAP: begin
               ticks_in = gap_ticks;
               if (gap_done) begin
                  phase_in = enough ? ura_pkg::PH_IDLE : ura_pkg::PH_LOW;
                  ticks_in = '0;
               end
            end
            default: begin
               phase_in = ura_pkg::PH_IDLE;
               if (start_req) begin
                  phase_in   = ura_pkg::PH_LOW;
                  ticks_in   = '0;
                  width_in   = '0;
                  started_in = 1'b0;
                  taken_in   = '0;
                  sum_in     = '0;
               end
            end
         endcase
      end
   end

   // tick outputs
   always_comb begin
      tick_res = '0;
      unique case (phase_ff)
         ura_pkg::PH_LOW:  tick_res.busy_res = 1'b1;
         ura_pkg::PH_TRIG: begin
            tick_res.busy_res    = 1'b1;
            tick_res.trigger_out = 1'b1;
         end
         ura_pkg::PH_ECHO: tick_res.busy_res = 1'b1;
         ura_pkg::PH_GAP: begin
            tick_res.busy_res = 1'b1;
            tick_res.calc_req = gap_done & enough;
         end
         default: ;
      endcase
   end

   assign sum_out   = sum_ff;
   assign count_out = wanted;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ura_pkg::PH_IDLE;
         ticks_ff   <= '0;
         width_ff   <= '0;
         started_ff <= 1'b0;
         taken_ff   <= '0;
         sum_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         ticks_ff   <= ticks_in;
         width_ff   <= width_in;
         started_ff <= started_in;
         taken_ff   <= taken_in;
         sum_ff     <= sum_in;
      end
   end

endmodule

### design/ura_calc.sv
// Bit-serial divide by reading count, then bit-serial multiply by speed scale.
module ura_calc #(
   parameter int unsigned MAX_READINGS = ura_pkg::MAX_READINGS_DEF,
   localparam int unsigned CNT_W = $clog2(MAX_READINGS + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ura_pkg::SUM_W-1:0]       sum_in,
   input  logic [CNT_W-1:0]                count_in,
   input  logic [ura_pkg::SCALE_W-1:0]     scale,
   input  logic [ura_pkg::DIST_W-1:0]      range,
   output ura_pkg::calc_res_type           calc_res
);

   localparam int unsigned SUM_W   = ura_pkg::SUM_W;
   localparam int unsigned SCALE_W = ura_pkg::SCALE_W;
   localparam int unsigned PROD_W  = ura_pkg::PROD_W;
   localparam int unsigned DIST_W  = ura_pkg::DIST_W;
   localparam int unsigned STEP_W  = $clog2(SUM_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

   ura_pkg::calc_state_type state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [SUM_W-1:0]   a_ff, a_in;      // dividend, then quotient
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [PROD_W-1:0]  p_ff, p_in;      // accumulator : multiplier

   logic               last;
   logic [CNT_W:0]     trial, trial_sub;
   logic               ge;
   logic [SUM_W-1:0]   a_shift;
   logic [SCALE_W:0]   madd;
   logic [SUM_W-1:0]   prod_hi;
   logic [DIST_W-1:0]  dist_sat;

   assign last      = step_ff == LAST_STEP;
   assign trial     = {rem_ff, a_ff[SUM_W-1]};
   assign trial_sub = trial - {1'b0, count_in};
   assign ge        = trial >= {1'b0, count_in};
   assign a_shift   = {a_ff[SUM_W-2:0], ge};
   assign madd      = {1'b0, p_ff[PROD_W-1:SUM_W]} + (p_ff[0] ? {1'b0, scale} : '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ura_pkg::CALC_IDLE: if (start) state_in = ura_pkg::CALC_DIV;
         ura_pkg::CALC_DIV:  if (last)  state_in = ura_pkg::CALC_MUL;
         ura_pkg::CALC_MUL:  if (last)  state_in = ura_pkg::CALC_FIN;
         ura_pkg::CALC_FIN:             state_in = ura_pkg::CALC_IDLE;
         default:                       state_in = ura_pkg::CALC_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      step_in = step_ff;
      a_in    = a_ff;
      rem_in  = rem_ff;
      p_in    = p_ff;
      unique case (state_ff)
         ura_pkg::CALC_IDLE: begin
            step_in = '0;
            a_in    = sum_in;
            rem_in  = '0;
         end
         ura_pkg::CALC_DIV: begin
            a_in    = a_shift;
            rem_in  = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            step_in = last ? '0 : step_ff + STEP_W'(1);
            if (last) p_in = {SCALE_W'(0), a_shift};
         end
         ura_pkg::CALC_MUL: begin
            p_in    = {madd, p_ff[SUM_W-1:1]};
            step_in = last ? '0 : step_ff + STEP_W'(1);
         end
         default: ;
      endcase
   end

   // drop the Q0.16 fraction and saturate
   assign prod_hi  = p_ff[PROD_W-1:SCALE_W];
   assign dist_sat = (prod_hi[SUM_W-1:DIST_W] != '0) ? ura_pkg::DIST_MAX
                                                      : prod_hi[DIST_W-1:0];

   // outputs
   always_comb begin
      calc_res             = '0;
      calc_res.distance_cm = dist_sat;
      calc_res.obstacle    = (dist_sat != '0) && (dist_sat <= range);
      unique case (state_ff)
         ura_pkg::CALC_FIN: calc_res.done = 1'b1;
         default:           calc_res.done = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ura_pkg::CALC_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      rem_ff <= rem_in;
      p_ff   <= p_in;
   end

endmodule

### design/ultrasonic_range_averager.sv
// Top level of the ultrasonic range averager: handshakes, result register, units.
//
// Channel   Direction  Handshake                  Item
// req_      in         req_tvalid / req_tready    one microsecond tick: start and echo level
// rsp_      out        rsp_tvalid / rsp_tready    one tick result: trigger, busy, distance
// csr_      in/out     APB write on psel&penable  six configuration registers at 4*i
//
// Cycles: ordinary ticks can enter every clock while results drain and no calculation
//  runs. The tick that closes a sequence runs the serial divider (20 steps, one quotient
//  bit a cycle) and the serial multiplier (20 steps, one multiplier bit a cycle); its
//  result enters the output register on done, from the FIN state after the multiplier.
// Reset: synchronous, active high; sequencer idle, sum and counts cleared.
// Stalls: a held-low rsp_tready keeps one result in the output register and
//  holds req_tready low; nothing is lost or repeated.
module ultrasonic_range_averager #(
   parameter int unsigned MAX_READINGS = ura_pkg::MAX_READINGS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: [0] start_req, [1] echo_level, rest zero
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ura_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // rsp_tdata: [0] trigger_out, [1] busy_res, [2] result_valid,
   //            [16:3] distance_cm, [17] obstacle, rest zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ura_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ura_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ura_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ura_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int unsigned CNT_W  = $clog2(MAX_READINGS + 1);
   localparam int unsigned DIST_W = ura_pkg::DIST_W;

   ura_pkg::cfg_type        cfg;
   ura_pkg::tick_res_type   tick_res;
   ura_pkg::calc_res_type   calc_res;
   ura_pkg::ctl_state_type  ctl_ff, ctl_in;

   logic [ura_pkg::SUM_W-1:0] seq_sum;
   logic [CNT_W-1:0]          seq_count;
   logic                      step, calc_start;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              trig_ff, trig_in;
   logic              busy_ff, busy_in;
   logic              resv_ff, resv_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic              obst_ff, obst_in;

   ura_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ura_seq #(
      .MAX_READINGS (MAX_READINGS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .start_req  (req_tdata[0]),
      .echo_level (req_tdata[1]),
      .cfg        (cfg),
      .tick_res   (tick_res),
      .sum_out    (seq_sum),
      .count_out  (seq_count)
   );

   ura_calc #(
      .MAX_READINGS (MAX_READINGS)
   ) u_calc (
      .clock    (clock),
      .reset    (reset),
      .start    (calc_start),
      .sum_in   (seq_sum),
      .count_in (seq_count),
      .scale    (cfg.speed_scale),
      .range    (cfg.obstacle_range),
      .calc_res (calc_res)
   );

   // next state: park in CALC while the serial unit works on the final tick
   always_comb begin
      ctl_in = ctl_ff;
      unique case (ctl_ff)
         ura_pkg::CTL_RUN:  if (step && tick_res.calc_req) ctl_in = ura_pkg::CTL_CALC;
         ura_pkg::CTL_CALC: if (calc_res.done)             ctl_in = ura_pkg::CTL_RUN;
         default:                                          ctl_in = ura_pkg::CTL_RUN;
      endcase
   end

   // handshake outputs
   always_comb begin
      unique case (ctl_ff)
         ura_pkg::CTL_RUN:  req_tready = ~rsp_valid_ff | rsp_tready;
         default:           req_tready = 1'b0;
      endcase
      step       = req_tvalid & req_tready;
      calc_start = step & tick_res.calc_req;
   end

   // output register: ordinary ticks load at acceptance, the final tick on done
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      trig_in      = trig_ff;
      busy_in      = busy_ff;
      resv_in      = resv_ff;
      dist_in      = dist_ff;
      obst_in      = obst_ff;
      if (step) begin
         rsp_valid_in = ~tick_res.calc_req;
         trig_in      = tick_res.trigger_out;
         busy_in      = tick_res.busy_res;
         resv_in      = tick_res.calc_req;
         dist_in      = '0;
         obst_in      = 1'b0;
      end else if (calc_res.done) begin
         rsp_valid_in = 1'b1;
         dist_in      = calc_res.distance_cm;
         obst_in      = calc_res.obstacle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= ura_pkg::CTL_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff       <= ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      trig_ff <= trig_in;
      busy_ff <= busy_in;
      resv_ff <= resv_in;
      dist_ff <= dist_in;
      obst_ff <= obst_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(ura_pkg::RSP_TDATA_W - ura_pkg::RSP_FIELD_W)'(0),
                        obst_ff, dist_ff, resv_ff, busy_ff, trig_ff};

endmodule

### bench/range_result_checker.sv
// Watches the tick and result channels, predicts each tick's result and compares.
`timescale 1ns / 100ps

module range_result_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [ura_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [ura_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ura_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ura_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  logic                             csr_pready,
   output int                               fail_count,
   output int                               pending
);
   import ura_pkg::*;

   // rsp_tdata layout, lowest bit last
   typedef struct packed {
      logic [RSP_TDATA_W-RSP_FIELD_W-1:0] pad;
      logic                               obstacle;
      logic [DIST_W-1:0]                  distance_cm;
      logic                               result_valid;
      logic                               busy_res;
      logic                               trigger_out;
   } tick_result_t;

   cfg_type            cfg;
   phase_type          rng_phase;
   logic [TICK_W-1:0]  rng_ticks;
   logic [WIDTH_W-1:0] rng_width;
   logic               rng_started;
   logic [7:0]         rng_taken;
   logic [SUM_W-1:0]   rng_sum;

   tick_result_t       expected_q[$];
   int                 reported;

   function automatic void close_reading(logic [WIDTH_W-1:0] w);
      logic [SUM_W:0] s;
      s = {1'b0, rng_sum} + (SUM_W+1)'(w >> 1);
      rng_sum = (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[SUM_W-1:0];
      if (rng_taken != 8'd255) rng_taken = rng_taken + 1'b1;
      rng_phase = PH_GAP;
      rng_ticks = '0;
   endfunction

   function automatic tick_result_t predict_tick(logic start, logic echo);
      tick_result_t       r;
      logic               ended;
      logic [7:0]         n_wanted;
      logic [SUM_W-1:0]   quot;
      logic [PROD_W-1:0]  prod;
      r = '0;
      r.busy_res = 1'b1;
      case (rng_phase)
         PH_LOW: begin
            rng_ticks = rng_ticks + 1'b1;
            if (rng_ticks >= LOW_TICKS) begin
               rng_phase = PH_TRIG;
               rng_ticks = '0;
            end
         end
         PH_TRIG: begin
            r.trigger_out = 1'b1;
            rng_ticks = rng_ticks + 1'b1;
            if (rng_ticks >= TICK_W'(cfg.trigger_width_us)) begin
               rng_phase   = PH_ECHO;
               rng_ticks   = '0;
               rng_width   = '0;
               rng_started = 1'b0;
            end
         end
         PH_ECHO: begin
            ended = 1'b0;
            rng_ticks = rng_ticks + 1'b1;
            if (!rng_started) begin
               if (echo) begin
                  rng_started = 1'b1;
                  rng_width   = WIDTH_W'(1);
               end
            end else if (echo) begin
               if (rng_width != WIDTH_MAX) rng_width = rng_width + 1'b1;
            end else begin
               ended = 1'b1;
            end
            // pulse end wins over the timeout on the same tick
            if (ended) close_reading(rng_width);
            else if (rng_ticks >= TICK_W'(cfg.timeout_us)) close_reading('0);
         end
         PH_GAP: begin
            if (rng_ticks != TICK_MAX) rng_ticks = rng_ticks + 1'b1;
            if (rng_ticks >= {cfg.timeout_us, 1'b0}) begin
               n_wanted = cfg.averaging_enable ? 8'(cfg.average_count) : 8'd1;
               if (n_wanted == 8'd0) n_wanted = 8'd1;
               if (n_wanted > 8'(MAX_READINGS_DEF)) n_wanted = 8'(MAX_READINGS_DEF);
               if (rng_taken >= n_wanted) begin
                  quot = SUM_W'(rng_sum / n_wanted);
                  prod = (PROD_W'(quot) * PROD_W'(cfg.speed_scale)) >> 16;
                  r.distance_cm  = (prod > PROD_W'(DIST_MAX)) ? DIST_MAX : prod[DIST_W-1:0];
                  r.obstacle     = (r.distance_cm != '0) &&
                                   (r.distance_cm <= cfg.obstacle_range);
                  r.result_valid = 1'b1;
                  rng_phase      = PH_IDLE;
               end else begin
                  rng_phase = PH_LOW;
               end
               rng_ticks = '0;
            end
         end
         default: begin
            // idle, and any stray code behaves as idle
            r.busy_res = 1'b0;
            rng_phase  = PH_IDLE;
            if (start) begin
               rng_phase   = PH_LOW;
               rng_ticks   = '0;
               rng_width   = '0;
               rng_started = 1'b0;
               rng_taken   = '0;
               rng_sum     = '0;
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      tick_result_t got;
      tick_result_t exp_res;
      if (reset) begin
         cfg         = '{TRIG_WIDTH_RST, TIMEOUT_RST, AVG_COUNT_RST, AVG_ENABLE_RST,
                         SCALE_RST, RANGE_RST};
         rng_phase   = PH_IDLE;
         rng_ticks   = '0;
         rng_width   = '0;
         rng_started = 1'b0;
         rng_taken   = '0;
         rng_sum     = '0;
         expected_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[4:2]))
               REG_TRIGGER_WIDTH: cfg.trigger_width_us = csr_pwdata[TRIG_W-1:0];
               REG_TIMEOUT:       cfg.timeout_us       = csr_pwdata[TMO_W-1:0];
               REG_AVERAGE_COUNT: cfg.average_count    = csr_pwdata[AVG_W-1:0];
               REG_AVERAGING_EN:  cfg.averaging_enable = csr_pwdata[0];
               REG_SPEED_SCALE:   cfg.speed_scale      = csr_pwdata[SCALE_W-1:0];
               REG_OBST_RANGE:    cfg.obstacle_range   = csr_pwdata[DIST_W-1:0];
               default: ;
            endcase
         end
         // results leave before this edge's tick is predicted
         if (rsp_tvalid && rsp_tready) begin
            got = tick_result_t'(rsp_tdata);
            if (expected_q.size() == 0) begin
               fail_count++;
               if (reported < 10) begin
                  reported++;
                  $display("%0t: result item with nothing expected, data %h", $realtime,
                           rsp_tdata);
               end
            end else begin
               exp_res = expected_q.pop_front();
               if (got.trigger_out !== exp_res.trigger_out ||
                   got.busy_res !== exp_res.busy_res ||
                   got.result_valid !== exp_res.result_valid ||
                   got.distance_cm !== exp_res.distance_cm ||
                   got.obstacle !== exp_res.obstacle ||
                   got.pad !== exp_res.pad) begin
                  fail_count++;
                  if (reported < 10) begin
                     reported++;
                     $display("%0t: mismatch exp trig %b busy %b valid %b dist %0d obst %b pad %h",
                              $realtime, exp_res.trigger_out, exp_res.busy_res,
                              exp_res.result_valid, exp_res.distance_cm, exp_res.obstacle,
                              exp_res.pad);
                     $display("%0t:          got trig %b busy %b valid %b dist %0d obst %b pad %h",
                              $realtime, got.trigger_out, got.busy_res, got.result_valid,
                              got.distance_cm, got.obstacle, got.pad);
                  end
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(predict_tick(req_tdata[0], req_tdata[1]));
      end
      pending = expected_q.size();
   end

endmodule

### bench/ultrasonic_range_averager_tb.sv
// Stimulus and verdict for the ultrasonic range averager; checking sits in the checker.
`timescale 1ns / 100ps

module ultrasonic_range_averager_tb;
   import ura_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;   // slowest legal run is well under this
   localparam int HOLD_CYCLES = 300;         // long receiver hold-off
   localparam int RAND_TICKS  = 750;
   localparam int RAND_RUNS   = 6;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // req_tdata: [0] start_req, [1] echo_level, rest zero
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // rsp_tdata: [0] trigger_out, [1] busy_res, [2] result_valid,
   //            [16:3] distance_cm, [17] obstacle, rest zero
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int ticks_sent = 0;

   // idling controls, percent chance per item / per cycle
   int gap_pct = 0;
   int stall_pct = 0;
   int hold_asks = 0;

   // what the stimulus needs to know of the current settings
   int cfg_tw, cfg_tmo, cfg_cnt, cfg_en;

   ultrasonic_range_averager DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   range_result_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always #1 clock = ~clock;

   // run-away guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   // The hold is counted here so the sender keeps pushing items meanwhile.
   int hold_done = 0;
   int hold_left = 0;
   int stall_left = 0;
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_asks != hold_done) begin
         hold_done = hold_asks;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // One tick item; called and returns on a falling edge.
   // tvalid is only dropped when a gap is taken, so it never toggles within a step.
   task automatic send_tick(input logic start, input logic echo);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W-2){1'b0}}, echo, start};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      ticks_sent++;
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
   endtask

   // APB write: setup then access; trailing cycle keeps psel edges apart
   task automatic write_reg(input reg_index_type idx, input int unsigned val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input int tw, input int tmo, input int cnt, input int en,
                             input int scale, input int obst_range);
      write_reg(REG_TRIGGER_WIDTH, tw);
      write_reg(REG_TIMEOUT, tmo);
      write_reg(REG_AVERAGE_COUNT, cnt);
      write_reg(REG_AVERAGING_EN, en);
      write_reg(REG_SPEED_SCALE, scale);
      write_reg(REG_OBST_RANGE, obst_range);
      cfg_tw  = tw;
      cfg_tmo = tmo;
      cfg_cnt = cnt;
      cfg_en  = en;
   endtask

   // stop offering items and let every expected result drain
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (8) @(negedge clock);
   endtask

   // occasional start request while busy - must be ignored
   function automatic logic stray_start();
      return $urandom_range(0, 7) == 0;
   endfunction

   // One complete measurement, laid out tick by tick from the settings:
   // start tick, then per reading 3 low ticks, the trigger pulse (at least one tick),
   // the echo window and the gap of twice the timeout (at least one tick).
   // fix_pw < 0 picks a random echo shape per reading.
   task automatic run_ranging(input int fix_dl, input int fix_pw);
      int n, tw1, tmo1, dl, pw, len, pick;
      n    = cfg_en ? cfg_cnt : 1;
      if (n < 1) n = 1;
      tw1  = (cfg_tw == 0) ? 1 : cfg_tw;
      tmo1 = (cfg_tmo == 0) ? 1 : cfg_tmo;
      send_tick(1'b1, $urandom_range(0, 1));
      for (int r = 0; r < n; r++) begin
         repeat (3) send_tick(stray_start(), $urandom_range(0, 1));
         repeat (tw1) send_tick(stray_start(), $urandom_range(0, 1));
         if (fix_pw >= 0) begin
            dl = fix_dl;
            pw = fix_pw;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               // no echo at all
               dl = 0;
               pw = 0;
            end else if (pick == 1) begin
               // pulse still high when the window closes
               dl = $urandom_range(0, tmo1 - 1);
               pw = tmo1 - dl + $urandom_range(0, 2);
            end else begin
               dl = $urandom_range(0, (tmo1 - 1) / 2);
               pw = $urandom_range(1, (tmo1 > dl + 1) ? tmo1 - dl - 1 : 1);
            end
         end
         // window ends on the first low after the pulse, or at the timeout
         if (pw == 0) len = tmo1;
         else len = (dl + pw + 1 < tmo1) ? dl + pw + 1 : tmo1;
         for (int k = 1; k <= len; k++)
            send_tick(stray_start(), (k > dl) && (k <= dl + pw));
         repeat ((cfg_tmo == 0) ? 1 : 2 * cfg_tmo)
            send_tick(stray_start(), $urandom_range(0, 1));
      end
   endtask

   initial begin
      int rand_start, runs_done, phase_no, runs, pick;
      int tw, tmo, cnt, en, scale, obst_range;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // idle ticks on reset settings, echo both levels
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      wait_drained();

      // zero trigger width, zero timeout, zero count: one-tick window reading 0
      set_config(0, 0, 0, 1, 65535, 0);
      run_ranging(0, 1);
      wait_drained();

      // single reading, pulse ends on the timeout tick: distance 1, obstacle set
      set_config(1, 6, 1, 0, 65535, 16383);
      run_ranging(0, 5);
      wait_drained();

      // random phases; first uses the deepest average, second the long hold-off
      rand_start = ticks_sent;
      runs_done  = 0;
      phase_no   = 0;
      while (ticks_sent - rand_start < RAND_TICKS || runs_done < RAND_RUNS) begin
         wait_drained();
         if (phase_no == 0) begin
            tw  = $urandom_range(0, 2);
            tmo = $urandom_range(0, 1);
            cnt = 63;
            en  = 1;
         end else begin
            pick = $urandom_range(0, 9);
            tw   = (pick < 7) ? $urandom_range(0, 4) :
                   (pick == 7) ? 255 : $urandom_range(0, 255);
            if ($urandom_range(0, 5) == 0) begin
               tmo = $urandom_range(13, 150);
               cnt = $urandom_range(0, 2);
            end else begin
               tmo = $urandom_range(0, 12);
               cnt = $urandom_range(0, 5);
            end
            en = $urandom_range(0, 1);
         end
         pick  = $urandom_range(0, 3);
         scale = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(0, 65535);
         pick  = $urandom_range(0, 3);
         obst_range = (pick == 0) ? 0 : (pick == 1) ? 16383 :
                      (pick == 2) ? $urandom_range(0, 8) : $urandom_range(0, 16383);
         set_config(tw, tmo, cnt, en, scale, obst_range);

         pick      = $urandom_range(0, 2);
         gap_pct   = (pick == 0) ? 0 : (pick == 1) ? 8 : 30;
         pick      = $urandom_range(0, 2);
         stall_pct = (pick == 0) ? 0 : (pick == 1) ? 8 : 30;
         if (phase_no == 1) hold_asks++;

         runs = (phase_no == 0) ? 1 : $urandom_range(2, 6);
         repeat (runs) begin
            repeat ($urandom_range(0, 3)) send_tick(1'b0, $urandom_range(0, 1));
            run_ranging(-1, -1);
            runs_done++;
         end
         phase_no++;
      end

      // closing part, no idling: widest trigger, pulse ending on the timeout tick
      wait_drained();
      gap_pct   = 0;
      stall_pct = 0;
      set_config(255, 20, 5, 0, 65535, 16383);
      run_ranging(0, 19);
      send_tick(1'b0, 1'b1);
      wait_drained();
      // closing tick runs divider and multiplier
      repeat (50) @(negedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### files.f
design/ura_pkg.sv
design/ura_csr.sv
design/ura_seq.sv
design/ura_calc.sv
design/ultrasonic_range_averager.sv
bench/range_result_checker.sv
bench/ultrasonic_range_averager_tb.sv
